FILE: design/mbps_pkg.sv
// shared types and constants of the masked byte pattern search core
// no dependencies; used by masked_byte_pattern_search_core, mbps_match_checker and the testbench top
package mbps_pkg;

    // default sizing of the core
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 48;

    // pattern register file holds 16 bytes whatever MAX_PATTERN is
    localparam int PATTERN_REG_BYTES = 16;

    // field widths
    localparam int ADDR_W    = 64;
    localparam int REGION_W  = 48;
    localparam int WILD_W    = 16;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_BITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE    = 3'd5;

    // one result item
    typedef struct packed {
        logic [ADDR_W-1:0] match_address;
        logic              is_match;
        logic              scan_done;
        logic              any_found;
    } t_result;

endpackage

FILE: design/masked_byte_pattern_search_core.sv
// masked byte pattern search core: streams bytes, reports masked pattern matches
// depends on mbps_pkg (types, register indexes, default sizing)
//
//  channel   direction  handshake                    payload
//  --------  ---------  ---------------------------  ------------------------------------
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata data_byte, tlast last_byte
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata match_address, tlast scan_done,
//                                                    tuser {any_found, is_match}
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while the queue has room for two results; a byte is compared
// against the aligned pattern while held in the input register, and its results land in a
// 4-deep queue whose head drives m_axis
// a byte whose results include both a match and the end marker pushes both in the same cycle;
// the queue drains them one per cycle while m_axis_tready is high
// reset (synchronous, active low) clears all control registers, the byte count and the queue
// input stalls only when the queue has fewer than two free slots; m_axis stalls never
// lose or repeat a result
// configuration is taken in any cycle and applies to bytes accepted from the next cycle on
module masked_byte_pattern_search_core #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // byte stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,   // [7:0] data_byte
    input  logic                                 s_axis_tlast,   // last_byte
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [mbps_pkg::ADDR_W-1:0]          m_axis_tdata,   // [63:0] match_address
    output logic                                 m_axis_tlast,   // scan_done
    output logic [1:0]                           m_axis_tuser,   // [0] is_match, [1] any_found
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mbps_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    // usable pattern length is bounded by both the register file and MAX_PATTERN
    localparam int USE_LEN = (MAX_PATTERN < mbps_pkg::PATTERN_REG_BYTES) ?
                             MAX_PATTERN : mbps_pkg::PATTERN_REG_BYTES;
    // previous bytes kept for the compare
    localparam int WIN     = (USE_LEN > 1) ? USE_LEN - 1 : 1;
    // width of the region limit compare
    localparam int LIM_W   = ((OFFSET_BITS > mbps_pkg::REGION_W) ?
                              OFFSET_BITS : mbps_pkg::REGION_W) + 1;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [OFFSET_BITS-1:0] CNT_MAX = {OFFSET_BITS{1'b1}};

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [63:0]                    r_pattern_low;
    logic [63:0]                    r_pattern_high;
    logic [mbps_pkg::WILD_W-1:0]    r_wildcard_bits;
    logic [mbps_pkg::LEN_W-1:0]     r_pattern_length;
    logic [mbps_pkg::ADDR_W-1:0]    r_base_address;
    logic [mbps_pkg::REGION_W-1:0]  r_region_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_wildcard_bits  <= '0;
            r_pattern_length <= '0;
            r_base_address   <= '0;
            r_region_size    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mbps_pkg::REG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                mbps_pkg::REG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                mbps_pkg::REG_WILDCARD_BITS:  r_wildcard_bits  <= i_cfg_data[mbps_pkg::WILD_W-1:0];
                mbps_pkg::REG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::REG_BASE_ADDRESS:   r_base_address   <= i_cfg_data;
                mbps_pkg::REG_REGION_SIZE:    r_region_size    <= i_cfg_data[mbps_pkg::REGION_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // derived settings, registered so the per-byte path stays short
    // ---------------------------------------------------------------
    logic [mbps_pkg::LEN_W-1:0]     len_used;
    logic [127:0]                   pattern_all;
    logic [7:0]                     n_apat  [USE_LEN];
    logic                           n_amask [USE_LEN];
    logic [7:0]                     r_apat  [USE_LEN];   // pattern byte compared at age a
    logic                           r_amask [USE_LEN];   // age a must compare equal
    logic                           r_len_nz;
    logic [mbps_pkg::LEN_W-1:0]     r_len_m1;
    logic [LIM_W-1:0]               r_limit;             // region_size + len - 1
    logic [mbps_pkg::ADDR_W-1:0]    r_addr_base;         // base_address - (len - 1)

    assign pattern_all = {r_pattern_high, r_pattern_low};

    always_comb begin
        len_used = r_pattern_length;
        if (len_used > mbps_pkg::LEN_W'(USE_LEN)) begin
            len_used = mbps_pkg::LEN_W'(USE_LEN);
        end
    end

    // pattern byte j lines up with the stream byte of age len-1-j
    always_comb begin
        logic [3:0] j;
        j = '0;
        for (int a = 0; a < USE_LEN; a++) begin
            if (mbps_pkg::LEN_W'(a) < len_used) begin
                j           = 4'(len_used - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(a));
                n_apat[a]   = pattern_all[j*8 +: 8];
                n_amask[a]  = !r_wildcard_bits[j];
            end else begin
                n_apat[a]   = '0;
                n_amask[a]  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_nz    <= 1'b0;
            r_len_m1    <= '0;
            r_limit     <= '0;
            r_addr_base <= '0;
            for (int a = 0; a < USE_LEN; a++) begin
                r_apat[a]  <= '0;
                r_amask[a] <= 1'b0;
            end
        end else begin
            r_len_nz    <= (len_used != '0);
            r_len_m1    <= len_used - mbps_pkg::LEN_W'(1);
            r_limit     <= LIM_W'(r_region_size) + LIM_W'(len_used) - LIM_W'(1);
            r_addr_base <= r_base_address - mbps_pkg::ADDR_W'(len_used)
                           + mbps_pkg::ADDR_W'(1);
            for (int a = 0; a < USE_LEN; a++) begin
                r_apat[a]  <= n_apat[a];
                r_amask[a] <= n_amask[a];
            end
        end
    end

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       proc_fire;
    logic       in_fire;

    assign s_axis_tready = !r_in_valid || proc_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_byte <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    // ---------------------------------------------------------------
    // compare stage: byte window, run count, match decision
    // ---------------------------------------------------------------
    logic [7:0]             r_win [WIN];     // r_win[0] is the byte before r_byte
    logic [OFFSET_BITS-1:0] r_seen;
    logic [OFFSET_BITS-1:0] n_seen;
    logic                   r_found;
    logic                   n_found;
    logic [7:0]             aged [USE_LEN];
    logic                   bytes_ok;
    logic                   hit;
    logic [mbps_pkg::ADDR_W-1:0] hit_addr;

    always_comb begin
        aged[0] = r_byte;
        for (int a = 1; a < USE_LEN; a++) begin
            aged[a] = r_win[a-1];
        end
    end

    always_comb begin
        bytes_ok = 1'b1;
        for (int a = 0; a < USE_LEN; a++) begin
            if (r_amask[a] && (aged[a] != r_apat[a])) begin
                bytes_ok = 1'b0;
            end
        end
    end

    // nonzero length, window complete, start offset inside the region, count not saturated, unmasked bytes equal
    assign hit = r_len_nz
              && (r_seen != CNT_MAX)
              && (r_seen >= OFFSET_BITS'(r_len_m1))
              && (LIM_W'(r_seen) < r_limit)
              && bytes_ok;

    assign hit_addr = r_addr_base + mbps_pkg::ADDR_W'(r_seen);

    always_comb begin
        n_seen  = (r_seen != CNT_MAX) ? r_seen + OFFSET_BITS'(1) : r_seen;
        n_found = r_found || hit;
        if (r_last) begin
            // end of run clears the stream state
            n_seen  = '0;
            n_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_found <= 1'b0;
        end else if (proc_fire) begin
            r_seen  <= n_seen;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_win[0] <= r_byte;
            for (int k = 1; k < WIN; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // result queue: up to two pushes per byte, at most one pop per cycle
    // ---------------------------------------------------------------
    mbps_pkg::t_result      r_q [QDEPTH];
    logic [QPTR_W-1:0]      r_wr_ptr;
    logic [QPTR_W-1:0]      r_rd_ptr;
    logic [QCNT_W-1:0]      r_count;
    logic [QCNT_W-1:0]      push_n;
    logic                   pop;
    logic [QPTR_W-1:0]      done_ptr;
    mbps_pkg::t_result      match_res;
    mbps_pkg::t_result      done_res;
    mbps_pkg::t_result      head;

    // room for the worst case of two results
    assign proc_fire = r_in_valid && (r_count <= QCNT_W'(QDEPTH - 2));

    assign push_n   = proc_fire ? (QCNT_W'(hit) + QCNT_W'(r_last)) : '0;
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign done_ptr = r_wr_ptr + QPTR_W'(hit);

    always_comb begin
        match_res.match_address = hit_addr;
        match_res.is_match      = 1'b1;
        match_res.scan_done     = 1'b0;
        match_res.any_found     = 1'b0;
        done_res.match_address  = '0;
        done_res.is_match       = 1'b0;
        done_res.scan_done      = 1'b1;
        done_res.any_found      = r_found || hit;
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            if (hit) begin
                r_q[r_wr_ptr] <= match_res;
            end
            if (r_last) begin
                r_q[done_ptr] <= done_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + QPTR_W'(pop);
            r_count  <= r_count + push_n - QCNT_W'(pop);
        end
    end

    assign head          = r_q[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = head.match_address;
    assign m_axis_tlast  = head.scan_done;
    assign m_axis_tuser  = {head.any_found, head.is_match};

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_queue_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != QCNT_W'(QDEPTH)) |-> ((r_wr_ptr - r_rd_ptr) == r_count[QPTR_W-1:0]))
        else $error("queue pointers disagree with fill count");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
        else $error("end marker carries match data");

    a_match_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[1])
        else $error("match result flags any_found");

    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_last) |=> (r_seen == '0 && !r_found))
        else $error("run state not cleared after last byte");

endmodule

FILE: tb/mbps_match_checker.sv
// result checker for the masked byte pattern search core
// predicts match and end marker results from the observed byte and register requests
// depends on mbps_pkg (t_result, field widths, register indexes, default sizing)
module mbps_match_checker
    import mbps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    input  logic                 i_s_ready,
    input  logic [7:0]           i_s_data,      // [7:0] data_byte
    input  logic                 i_s_last,      // last_byte
    input  logic                 i_m_valid,
    input  logic                 i_m_ready,
    input  logic [ADDR_W-1:0]    i_m_data,      // [63:0] match_address
    input  logic                 i_m_last,      // scan_done
    input  logic [1:0]           i_m_user,      // [0] is_match, [1] any_found
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int HISTORY_DEPTH = MAX_PATTERN_DEF - 1;
    localparam logic [OFFSET_BITS_DEF-1:0] COUNT_MAX = '1;

    // register copies
    logic [8*PATTERN_REG_BYTES-1:0] pat_bytes;
    logic [WILD_W-1:0]              wild_mask;
    logic [LEN_W-1:0]               len_reg;
    logic [ADDR_W-1:0]              base_addr;
    logic [REGION_W-1:0]            region_len;

    // stream state
    logic [7:0]                 history [HISTORY_DEPTH];
    logic [OFFSET_BITS_DEF-1:0] seen_count;
    bit                         run_found;

    t_result expected_results[$];
    t_result want;
    int      mismatch_count;
    int      results_checked;

    function automatic void clear_run();
        foreach (history[i]) history[i] = 8'h00;
        seen_count = '0;
        run_found  = 1'b0;
    endfunction

    // expected results leave from the front in arrival order
    function automatic void queue_expected(input t_result res);
        expected_results.insert(expected_results.size(), res);
    endfunction

    function automatic void predict_scan_step(input logic [7:0] cur, input logic is_last);
        int                       len;
        int                       j;
        int                       age;
        logic [OFFSET_BITS_DEF:0] next_count;
        logic [OFFSET_BITS_DEF-1:0] start;
        logic [7:0]               seen_byte;
        bit                       hit;
        t_result                  res;
        len = int'(len_reg);
        if (len > PATTERN_REG_BYTES) len = PATTERN_REG_BYTES;
        if (len > MAX_PATTERN_DEF) len = MAX_PATTERN_DEF;
        next_count = {1'b0, seen_count} + 1'b1;
        // only the start whose window just completed is tested
        if (len > 0 && seen_count != COUNT_MAX && next_count >= len) begin
            start = OFFSET_BITS_DEF'(next_count - len);
            hit = (start < region_len);
            for (j = 0; j < len; j++) begin
                if (!wild_mask[j]) begin
                    age = len - 1 - j;
                    seen_byte = (age == 0) ? cur : history[age-1];
                    if (seen_byte != pat_bytes[j*8 +: 8]) hit = 1'b0;
                end
            end
            if (hit) begin
                res.match_address = base_addr + ADDR_W'(start);
                res.is_match      = 1'b1;
                res.scan_done     = 1'b0;
                res.any_found     = 1'b0;
                queue_expected(res);
                run_found = 1'b1;
            end
        end
        if (seen_count != COUNT_MAX) seen_count = next_count[OFFSET_BITS_DEF-1:0];
        for (j = HISTORY_DEPTH - 1; j > 0; j--) history[j] = history[j-1];
        history[0] = cur;
        if (is_last) begin
            res.match_address = '0;
            res.is_match      = 1'b0;
            res.scan_done     = 1'b1;
            res.any_found     = run_found;
            queue_expected(res);
            clear_run();
        end
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_bytes  = '0;
            wild_mask  = '0;
            len_reg    = '0;
            base_addr  = '0;
            region_len = '0;
            clear_run();
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PATTERN_LOW:    pat_bytes[63:0]   = i_cfg_data;
                    REG_PATTERN_HIGH:   pat_bytes[127:64] = i_cfg_data;
                    REG_WILDCARD_BITS:  wild_mask  = i_cfg_data[WILD_W-1:0];
                    REG_PATTERN_LENGTH: len_reg    = i_cfg_data[LEN_W-1:0];
                    REG_BASE_ADDRESS:   base_addr  = i_cfg_data;
                    REG_REGION_SIZE:    region_len = i_cfg_data[REGION_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) predict_scan_step(i_s_data, i_s_last);
            if (i_m_valid && i_m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: match_address %0h scan_done %b tuser %b",
                           i_m_data, i_m_last, i_m_user);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("match_address", want.match_address, i_m_data);
                    compare_field("is_match", 64'(want.is_match), 64'(i_m_user[0]));
                    compare_field("scan_done", 64'(want.scan_done), 64'(i_m_last));
                    compare_field("any_found", 64'(want.any_found), 64'(i_m_user[1]));
                    results_checked++;
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatch_count;
        o_checked    <= results_checked;
    end

endmodule

FILE: tb/masked_byte_pattern_search_core_test.sv
// top of the masked byte pattern search core testbench: clock, reset, stimulus, verdict
// depends on mbps_pkg, masked_byte_pattern_search_core and mbps_match_checker
module masked_byte_pattern_search_core_test;
    import mbps_pkg::*;

    localparam int RANDOM_BYTES     = 1950;
    localparam int STALL_LIMIT      = 5000;  // cycles with no request moving on any channel
    localparam int DRAIN_CYCLES     = 8;     // settling wait once every expected result is out
    localparam int CFG_SETTLE       = 3;     // time for a write to pass the configuration and derived registers
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int FLOOD_BYTES      = 40;

    // indexes with no register behind them, written to see that nothing changes
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic                 s_axis_tlast = 1'b0;    // last_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [ADDR_W-1:0]    m_axis_tdata;           // [63:0] match_address
    logic                 m_axis_tlast;           // scan_done
    logic [1:0]           m_axis_tuser;           // [0] is_match, [1] any_found
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending_count;
    int checked_count;

    // stimulus side copies of the pattern registers, used to plant matches
    logic [8*PATTERN_REG_BYTES-1:0] plant_pattern = '0;
    logic [WILD_W-1:0]              plant_wild = '0;
    logic [LEN_W-1:0]               plant_len_reg = '0;

    int bytes_sent = 0;
    int runs_sent  = 0;
    int cfg_writes = 0;
    bit calm       = 1'b0;   // no idling on either side once set
    int hold_tag   = 0;      // bumped to ask the result side for one long hold-off

    // result side pacing state
    int sink_run    = 0;
    int sink_stall  = 0;
    int sink_hold   = 0;
    int hold_served = 0;

    always #5 i_clk = ~i_clk;

    masked_byte_pattern_search_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    mbps_match_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_s_last     (s_axis_tlast),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .i_m_last     (m_axis_tlast),
        .i_m_user     (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    // result side: random ready bursts, one long hold-off per hold_tag bump
    always @(posedge i_clk) begin
        if (hold_tag != hold_served) begin
            hold_served = hold_tag;
            sink_hold   = LONG_HOLD_CYCLES;
        end
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (sink_run == 0 && sink_stall == 0) begin
                if ($urandom_range(0, 2) == 0) sink_stall = $urandom_range(1, 12);
                else sink_run = $urandom_range(1, 40);
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                sink_run--;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: ends the run when no request moves for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // one byte request, with an occasional idle burst in front of it
    task automatic send_byte(input logic [7:0] data_byte, input logic is_last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data_byte;
        s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        if (is_last) runs_sent++;
    endtask

    // one register write request; valid stays up for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_writes++;
        case (index)
            REG_PATTERN_LOW:    plant_pattern[63:0]   = data;
            REG_PATTERN_HIGH:   plant_pattern[127:64] = data;
            REG_WILDCARD_BITS:  plant_wild    = data[WILD_W-1:0];
            REG_PATTERN_LENGTH: plant_len_reg = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // sender stops until every expected result is out, then lets the pipe drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // drop the write valid and give the new settings time to reach the compare stage
    task automatic settle_config();
        i_cfg_valid <= 1'b0;
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    // random settings for every register, extremes weighted in, junk above the narrow fields
    task automatic random_setup();
        logic [63:0] field;
        int          pick;
        wait_idle();

        pick = $urandom_range(0, 7);
        field = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
        cfg_write(REG_PATTERN_LOW, field);
        pick = $urandom_range(0, 7);
        field = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
        cfg_write(REG_PATTERN_HIGH, field);

        pick = $urandom_range(0, 9);
        if (pick == 0) field = 64'h0;
        else if (pick == 1) field = 64'hFFFF;
        else if (pick < 5) field = 64'($urandom_range(0, 16'hFFFF));
        else field = 64'($urandom & $urandom & $urandom & 32'hFFFF);
        cfg_write(REG_WILDCARD_BITS, ({$urandom, $urandom} & ~64'hFFFF) | field);

        // mostly short patterns; zero, full and overlong lengths now and then
        pick = $urandom_range(0, 19);
        if (pick == 0) field = 64'd0;
        else if (pick == 1) field = 64'($urandom_range(17, 31));
        else if (pick < 4) field = 64'd16;
        else if (pick < 8) field = 64'($urandom_range(7, 15));
        else field = 64'($urandom_range(1, 6));
        cfg_write(REG_PATTERN_LENGTH, ({$urandom, $urandom} & ~64'h1F) | field);

        // top of the address space makes reported addresses wrap
        pick = $urandom_range(0, 5);
        if (pick == 0) field = 64'h0;
        else if (pick == 1) field = '1 - 64'($urandom_range(0, 40));
        else field = {$urandom, $urandom};
        cfg_write(REG_BASE_ADDRESS, field);

        // small regions cut starts off inside the run
        pick = $urandom_range(0, 9);
        if (pick < 2) field = 64'hFFFF_FFFF_FFFF;
        else if (pick == 2) field = 64'h0;
        else if (pick < 7) field = 64'($urandom_range(0, 60));
        else field = {16'h0, 16'($urandom), $urandom};
        cfg_write(REG_REGION_SIZE, ({$urandom, $urandom} & ~64'hFFFF_FFFF_FFFF) | field);

        if ($urandom_range(0, 7) == 0)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
        settle_config();
    endtask

    // random run with planted pattern copies; some copies get one byte spoiled
    task automatic scan_run(input int run_len, input bit end_run);
        int         pos;
        int         j;
        int         len;
        int         spoil;
        logic [7:0] data_byte;
        len = (plant_len_reg > LEN_W'(PATTERN_REG_BYTES)) ? PATTERN_REG_BYTES
                                                         : int'(plant_len_reg);
        pos = 0;
        while (pos < run_len) begin
            if (len > 0 && pos + len <= run_len && $urandom_range(0, 3) == 0) begin
                spoil = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;
                for (j = 0; j < len; j++) begin
                    data_byte = plant_wild[j] ? 8'($urandom) : plant_pattern[j*8 +: 8];
                    if (j == spoil) data_byte ^= 8'(1 << $urandom_range(0, 7));
                    send_byte(data_byte, end_run && pos == run_len - 1);
                    pos++;
                end
            end else begin
                send_byte(8'($urandom), end_run && pos == run_len - 1);
                pos++;
            end
        end
    endtask

    // every byte matches, so results pile up while the result side holds off
    // and the byte input has to stall
    task automatic flood_with_hold();
        int k;
        wait_idle();
        cfg_write(REG_WILDCARD_BITS, 64'h1);
        cfg_write(REG_PATTERN_LENGTH, 64'd1);
        cfg_write(REG_REGION_SIZE, 64'hFFFF_FFFF_FFFF);
        cfg_write(REG_BASE_ADDRESS, {$urandom, $urandom});
        settle_config();
        hold_tag <= hold_tag + 1;
        for (k = 0; k < FLOOD_BYTES; k++) send_byte(8'($urandom), k == FLOOD_BYTES - 1);
    endtask

    initial begin : stimulus
        int random_start;
        int run_len;
        int flood_count;
        int k;
        flood_count = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero length never matches, even on matching bytes; the end marker still comes
        cfg_write(REG_PATTERN_LOW, 64'h0);
        cfg_write(REG_PATTERN_HIGH, 64'h0);
        cfg_write(REG_WILDCARD_BITS, 64'h0);
        cfg_write(REG_PATTERN_LENGTH, 64'd0);
        cfg_write(REG_BASE_ADDRESS, 64'h0);
        cfg_write(REG_REGION_SIZE, 64'hFFFF_FFFF_FFFF);
        settle_config();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);

        // exact four byte pattern; first copy starts outside a one byte region
        wait_idle();
        cfg_write(REG_PATTERN_LOW, 64'h0000_0000_EFBE_ADDE);
        cfg_write(REG_PATTERN_LENGTH, 64'd4);
        cfg_write(REG_BASE_ADDRESS, 64'h1000);
        cfg_write(REG_REGION_SIZE, 64'd1);
        settle_config();
        send_byte(8'h00, 1'b0);
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b0);
        // widen the region mid-run; window and count carry on
        wait_idle();
        cfg_write(REG_REGION_SIZE, 64'd16);
        settle_config();
        // second copy completes on the last byte: match first, then the end marker,
        // and the starts left open by the short tail are dropped
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b1);

        // overlong length clamps to 16, odd bytes wild, all-ones pattern and base
        wait_idle();
        cfg_write(REG_PATTERN_LOW, '1);
        cfg_write(REG_PATTERN_HIGH, '1);
        cfg_write(REG_WILDCARD_BITS, 64'hAAAA);
        cfg_write(REG_PATTERN_LENGTH, 64'd31);
        cfg_write(REG_BASE_ADDRESS, '1);
        cfg_write(REG_REGION_SIZE, 64'hFFFF_FFFF_FFFF);
        settle_config();
        for (k = 0; k < 16; k++) send_byte(k[0] ? 8'h00 : 8'hFF, k == 15);

        // random runs; some are split by a mid-run rewrite of the registers
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if (bytes_sent - random_start >= RANDOM_BYTES * 9 / 10) calm <= 1'b1;
            if (flood_count < 2 &&
                bytes_sent - random_start >= (flood_count + 1) * RANDOM_BYTES / 3) begin
                flood_with_hold();
                flood_count++;
            end
            random_setup();
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                  : $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) begin
                scan_run(run_len, 1'b0);
                random_setup();
                run_len = $urandom_range(1, 30);
            end
            scan_run(run_len, 1'b1);
        end

        wait_idle();
        $display("scanned %0d bytes in %0d runs with %0d register writes",
                 bytes_sent, runs_sent, cfg_writes);
        $display("compared %0d results, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
